/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the stack block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is disabled while reset is held.
`define ASSERT_CLK(label, clock, resetn, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) prop) \
        else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clock, prop, msg) \
    label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/slstk_pkg.sv */
// Package with operation codes, status codes and fixed field widths of the stack block.
`default_nettype none
package slstk_pkg;

    localparam int WORD_W   = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 5;

    localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
    localparam logic [OP_W-1:0] OP_POP     = 3'd1;
    localparam logic [OP_W-1:0] OP_SEARCH  = 3'd2;
    localparam logic [OP_W-1:0] OP_REPLACE = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

endpackage
`default_nettype wire

/* rtl/searchable_lifo_stack_top.sv */
// Searchable LIFO stack: control state machine around one word memory.
// Push and any command on an empty stack answer with one result beat in the cycle after the
// command beat; unused codes give no result. Pop answers after the registered read of the top.
// Search and replace walk the memory one entry per cycle from the top until the first match
// or the bottom entry. Dump gives one result beat per cycle after the registered read of the
// top entry. Reset (rst_n low) empties the stack at once.
`default_nettype none
module searchable_lifo_stack_top
    import slstk_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic        [OP_W-1:0]     op,
    input  wire logic signed [WORD_W-1:0]   value,
    input  wire logic signed [WORD_W-1:0]   new_value,
    output logic                            done,
    output logic             [STATUS_W-1:0] status,
    output logic signed      [WORD_W-1:0]   data,
    output logic             [POS_W-1:0]    position,
    output logic                            last
);

    // Address width covers the entries; the count needs one more value to hold DEPTH itself.
    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_DUMP
    } state_t;

    state_t state_reg, state_next;

    // Number of held words; entry 0 is the bottom, entry count-1 the top.
    logic [CW-1:0] count_reg, count_next;

    // Address of the entry whose word arrives on the read port in the current cycle.
    logic [IW-1:0] addr_reg, addr_next;

    // Position from the top of that entry, masked to the field width as it counts.
    logic [POS_W-1:0] pos_reg, pos_next;

    // Operands of a search or replace held for the whole walk.
    logic [WORD_W-1:0] key_reg, key_next;
    logic [WORD_W-1:0] nv_reg, nv_next;
    logic              repl_reg, repl_next;

    // Registered result beat.
    logic                done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [WORD_W-1:0]   data_reg, data_next;
    logic [POS_W-1:0]    position_reg, position_next;
    logic                last_reg, last_next;

    // Memory port signals.
    logic              we;
    logic [IW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [IW-1:0]     rd_addr;
    logic [WORD_W-1:0] rd_data;

    logic [CW-1:0] count_m1;
    logic [IW-1:0] top_addr;
    logic          empty;
    logic          full;

    assign count_m1 = count_reg - CW'(1);
    assign top_addr = count_m1[IW-1:0];
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == FULL_COUNT);

    slstk_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Commands are taken only in idle, so no read whose word is used falls in the same cycle as
    // a write of that entry: every write lands before the next such read of it.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        addr_next     = addr_reg;
        pos_next      = pos_reg;
        key_next      = key_reg;
        nv_next       = nv_reg;
        repl_next     = repl_reg;
        done_next     = 1'b0;
        status_next   = ST_OK;
        data_next     = '0;
        position_next = '0;
        last_next     = 1'b0;
        we            = 1'b0;
        wr_addr       = count_reg[IW-1:0];
        wr_data       = $unsigned(value);
        rd_addr       = addr_reg - IW'(1);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (op)
                        OP_PUSH:
                        begin
                            done_next = 1'b1;
                            last_next = 1'b1;
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_POP:
                        begin
                            if (empty)
                            begin
                                done_next   = 1'b1;
                                last_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_m1;
                                rd_addr    = top_addr;
                                state_next = S_POP;
                            end
                        end
                        OP_SEARCH, OP_REPLACE:
                        begin
                            if (empty)
                            begin
                                done_next   = 1'b1;
                                last_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                key_next   = $unsigned(value);
                                nv_next    = $unsigned(new_value);
                                repl_next  = (op == OP_REPLACE);
                                addr_next  = top_addr;
                                rd_addr    = top_addr;
                                pos_next   = POS_W'(1);
                                state_next = S_SCAN;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (empty)
                            begin
                                done_next   = 1'b1;
                                last_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                addr_next  = top_addr;
                                rd_addr    = top_addr;
                                state_next = S_DUMP;
                            end
                        end
                        default:
                        begin
                            // Unused codes cause no result and leave the stack alone.
                        end
                    endcase
                end
            end
            S_POP:
            begin
                done_next  = 1'b1;
                last_next  = 1'b1;
                data_next  = rd_data;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (rd_data == key_reg)
                begin
                    // First match from the top; a replace rewrites that same entry.
                    we            = repl_reg;
                    wr_addr       = addr_reg;
                    wr_data       = nv_reg;
                    done_next     = 1'b1;
                    last_next     = 1'b1;
                    position_next = pos_reg;
                    state_next    = S_IDLE;
                end
                else if (addr_reg == '0)
                begin
                    done_next   = 1'b1;
                    last_next   = 1'b1;
                    status_next = ST_NOTFOUND;
                    state_next  = S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg - IW'(1);
                    pos_next  = pos_reg + POS_W'(1);
                end
            end
            S_DUMP:
            begin
                done_next = 1'b1;
                data_next = rd_data;
                if (addr_reg == '0)
                begin
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg - IW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        pos_reg      <= pos_next;
        key_reg      <= key_next;
        nv_reg       <= nv_next;
        repl_reg     <= repl_next;
        status_reg   <= status_next;
        data_reg     <= data_next;
        position_reg <= position_next;
        last_reg     <= last_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign status   = status_reg;
    assign data     = $signed(data_reg);
    assign position = position_reg;
    assign last     = last_reg;

endmodule
`default_nettype wire

/* rtl/slstk_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module slstk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

/* rtl/slstk_checker.sv */
// Port-level checker for the stack block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module slstk_checker
    import slstk_pkg::*;
(
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic        [OP_W-1:0]     op,
    input wire logic                       done,
    input wire logic        [STATUS_W-1:0] status,
    input wire logic signed [WORD_W-1:0]   data,
    input wire logic        [POS_W-1:0]    position,
    input wire logic                       last
);

    logic cmd_beat;
    logic bad_op;

    assign cmd_beat = start && !busy;
    assign bad_op   = (op != OP_PUSH) && (op != OP_POP) && (op != OP_SEARCH) &&
                      (op != OP_REPLACE) && (op != OP_DUMP);

    // A push always answers with a single final beat in the next cycle.
    `ASSERT_CLK(a_push_answer, clk, rst_n, cmd_beat && (op == OP_PUSH) |=> done && last, "push without result beat")

    // Unused codes produce no beat.
    `ASSERT_CLK(a_bad_op_silent, clk, rst_n, cmd_beat && bad_op |=> !done, "result beat for unused code")

    // Only a dump produces more than one beat, and its beats come back to back.
    `ASSERT_CLK(a_dump_runs, clk, rst_n, done && !last |=> done, "gap inside a dump")

    // Error answers are single final beats with zero data and position.
    `ASSERT_CLK(a_error_beat, clk, rst_n, done && (status != ST_OK) |-> last && (data == 0) && (position == 0), "malformed error beat")

    // A running command keeps the block busy until its final beat has been issued.
    `ASSERT_CLK(a_busy_until_last, clk, rst_n, done && !last |-> $past(busy), "dump beat while idle")

endmodule

bind searchable_lifo_stack_top slstk_checker u_slstk_checker (.*);
`default_nettype wire
